### rtl/track_overcurrent_trip_retry_assert.svh
// Assertion macros used by the top-level RTL file.
`ifndef TRACK_OVERCURRENT_TRIP_RETRY_ASSERT_SVH
`define TRACK_OVERCURRENT_TRIP_RETRY_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TOTR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define TOTR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define TOTR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TOTR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/totr_pkg.sv
package totr_pkg;

    localparam int REG_W      = 16;
    localparam int ALPHA_W    = 9;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [REG_W-1:0]   PROG_LIMIT_MA = 16'd250;
    localparam logic [REG_W-1:0]   CURRENT_MAX   = 16'hFFFF;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE     = 9'd256;

    localparam logic [REG_W-1:0]   RST_TRIP_MA   = 16'd2000;
    localparam logic [REG_W-1:0]   RST_FACTOR    = 16'd1;
    localparam logic [REG_W-1:0]   RST_DIVISOR   = 16'd1;
    localparam logic [REG_W-1:0]   RST_WINDOW    = 16'd100;
    localparam logic [REG_W-1:0]   RST_PERIOD    = 16'd1;
    localparam logic [REG_W-1:0]   RST_RETRY     = 16'd1000;
    localparam logic [ALPHA_W-1:0] RST_ALPHA     = 9'd64;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_POWER = 2'd1,
        CMD_PROG  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_OFF  = 2'd1,
        EV_ON   = 2'd2
    } power_event_t;

    typedef enum logic [2:0] {
        REG_TRIP    = 3'd0,
        REG_FACTOR  = 3'd1,
        REG_DIVISOR = 3'd2,
        REG_WINDOW  = 3'd3,
        REG_PERIOD  = 3'd4,
        REG_RETRY   = 3'd5,
        REG_ALPHA   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### rtl/track_overcurrent_trip_retry.sv
// Overcurrent guard with automatic retry for a track driver. Items on the s_ channel are
// commands: a tick advances the millisecond clock and brings one ADC sample, set power drives
// the enable, set mode switches programming mode (250 mA limit inside the window and after it
// expires). Every item gives exactly one result transfer on the m_ channel. Items are handled
// one at a time; s_ready is high only while the sequencer is idle. A command item finishes in
// idle, a tick that does not reach the sample period in the check state, and a tick that runs a
// check in the decide state after the mix, average, scale, divide, saturate and limit states:
// one shared multiplier forms the average in two passes and scales it, then a serial divider
// produces one quotient bit per cycle. The next item can be taken once the result is in the
// output register. A pending result that is not taken holds the sequencer until m_ready.
// Registers must be written over the APB port only while the block is idle (not enforced).

`include "track_overcurrent_trip_retry_assert.svh"

module track_overcurrent_trip_retry #(
    parameter int ADC_BITS  = 10,
    parameter int FRAC_BITS = 8,
    parameter int TIME_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_cmd,
    input  logic [ADC_BITS-1:0]               s_sample,
    input  logic                              s_value,
    input  logic                              s_announce,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_power_enabled,
    output logic                              m_is_tripped,
    output logic [15:0]                       m_current_ma,
    output logic [1:0]                        m_power_event,
    output logic                              m_limiting,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [totr_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [totr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [totr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int REG_W   = totr_pkg::REG_W;
    localparam int ALPHA_W = totr_pkg::ALPHA_W;
    localparam int AVG_W   = ADC_BITS + FRAC_BITS;
    localparam int MIX_W   = AVG_W + ALPHA_W;
    localparam int PROD_W  = AVG_W + REG_W;
    localparam int DVD_W   = ADC_BITS + REG_W;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_TICK   = 11'b000_0000_0010,
        ST_CHECK  = 11'b000_0000_0100,
        ST_MIX_A  = 11'b000_0000_1000,
        ST_MIX_B  = 11'b000_0001_0000,
        ST_AVG    = 11'b000_0010_0000,
        ST_SCALE  = 11'b000_0100_0000,
        ST_DIV    = 11'b000_1000_0000,
        ST_SAT    = 11'b001_0000_0000,
        ST_LIMIT  = 11'b010_0000_0000,
        ST_DECIDE = 11'b100_0000_0000
    } state_t;

    // config registers
    logic [REG_W-1:0]   trip_reg;
    logic [REG_W-1:0]   factor_reg;
    logic [REG_W-1:0]   divisor_reg;
    logic [REG_W-1:0]   window_reg;
    logic [REG_W-1:0]   period_reg;
    logic [REG_W-1:0]   retry_reg;
    logic [ALPHA_W-1:0] alpha_reg;

    // block state
    state_t               state_reg, state_next;
    logic                 finish_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [TIME_BITS-1:0] last_check_reg;
    logic [TIME_BITS-1:0] prog_start_reg;
    logic [TIME_BITS-1:0] last_trip_reg;
    logic [AVG_W-1:0]     avg_reg;
    logic [REG_W-1:0]     window_left_reg;
    logic                 enabled_reg;
    logic                 tripped_reg;
    logic                 prog_reg;
    logic [REG_W-1:0]     current_reg;
    logic                 limit_reg;
    totr_pkg::power_event_t ev_reg;
    logic [ADC_BITS-1:0]  sample_reg;
    logic [MIX_W-1:0]     acc_reg;

    // output register
    logic                 m_valid_reg;
    logic                 m_enabled_reg;
    logic                 m_tripped_reg;
    logic [REG_W-1:0]     m_current_reg;
    logic [1:0]           m_event_reg;
    logic                 m_limiting_reg;

    logic                 cfg_wr;
    logic                 in_xfer;
    logic                 out_load;
    logic [ALPHA_W-1:0]   alpha_eff;
    logic [AVG_W-1:0]     mul_a;
    logic [REG_W-1:0]     mul_b;
    logic [PROD_W-1:0]    prod;
    logic [TIME_BITS-1:0] time_b;
    logic [TIME_BITS-1:0] since;
    logic [TIME_BITS-1:0] window_ext;
    logic [REG_W-1:0]     divisor_eff;
    logic [REG_W-1:0]     limit_ma;
    logic                 div_start;
    totr_pkg::div_stat_t  div_stat;
    logic [DVD_W-1:0]     quotient;

    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign s_ready  = (state_reg == ST_IDLE) && !finish_reg;
    assign in_xfer  = s_valid && s_ready;
    assign out_load = finish_reg && (!m_valid_reg || m_ready);

    // ---------------- APB registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trip_reg    <= totr_pkg::RST_TRIP_MA;
            factor_reg  <= totr_pkg::RST_FACTOR;
            divisor_reg <= totr_pkg::RST_DIVISOR;
            window_reg  <= totr_pkg::RST_WINDOW;
            period_reg  <= totr_pkg::RST_PERIOD;
            retry_reg   <= totr_pkg::RST_RETRY;
            alpha_reg   <= totr_pkg::RST_ALPHA;
        end else if (cfg_wr) begin
            case (totr_pkg::reg_idx_t'(paddr[4:2]))
                totr_pkg::REG_TRIP:    trip_reg    <= pwdata[REG_W-1:0];
                totr_pkg::REG_FACTOR:  factor_reg  <= pwdata[REG_W-1:0];
                totr_pkg::REG_DIVISOR: divisor_reg <= pwdata[REG_W-1:0];
                totr_pkg::REG_WINDOW:  window_reg  <= pwdata[REG_W-1:0];
                totr_pkg::REG_PERIOD:  period_reg  <= pwdata[REG_W-1:0];
                totr_pkg::REG_RETRY:   retry_reg   <= pwdata[REG_W-1:0];
                totr_pkg::REG_ALPHA:   alpha_reg   <= pwdata[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (totr_pkg::reg_idx_t'(paddr[4:2]))
            totr_pkg::REG_TRIP:    prdata = 32'(trip_reg);
            totr_pkg::REG_FACTOR:  prdata = 32'(factor_reg);
            totr_pkg::REG_DIVISOR: prdata = 32'(divisor_reg);
            totr_pkg::REG_WINDOW:  prdata = 32'(window_reg);
            totr_pkg::REG_PERIOD:  prdata = 32'(period_reg);
            totr_pkg::REG_RETRY:   prdata = 32'(retry_reg);
            totr_pkg::REG_ALPHA:   prdata = 32'(alpha_reg);
            default:               prdata = '0;
        endcase
    end

    // ---------------- shared datapath ----------------
    assign alpha_eff   = (alpha_reg > totr_pkg::ALPHA_ONE) ? totr_pkg::ALPHA_ONE : alpha_reg;
    assign divisor_eff = (divisor_reg == '0) ? REG_W'(1) : divisor_reg;
    assign limit_ma    = limit_reg ? totr_pkg::PROG_LIMIT_MA : trip_reg;
    assign window_ext  = TIME_BITS'(window_left_reg);

    always_comb begin
        case (state_reg)
            ST_MIX_A: begin
                mul_a = {sample_reg, {FRAC_BITS{1'b0}}};
                mul_b = REG_W'(alpha_eff);
            end
            ST_MIX_B: begin
                mul_a = avg_reg;
                mul_b = REG_W'(totr_pkg::ALPHA_ONE - alpha_eff);
            end
            default: begin
                mul_a = AVG_W'(avg_reg[AVG_W-1:FRAC_BITS]);
                mul_b = factor_reg;
            end
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // one subtractor for all elapsed-time checks
    always_comb begin
        case (state_reg)
            ST_CHECK:  time_b = last_check_reg;
            ST_DECIDE: time_b = last_trip_reg;
            default:   time_b = prog_start_reg;
        endcase
    end

    assign since = now_reg - time_b;

    assign div_start = (state_reg == ST_SCALE);

    totr_div #(
        .DVD_W (DVD_W),
        .DSR_W (REG_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod[DVD_W-1:0]),
        .divisor  (divisor_eff),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer && totr_pkg::cmd_t'(s_cmd) == totr_pkg::CMD_TICK) begin
                    state_next = ST_TICK;
                end
            end
            ST_TICK:   state_next = ST_CHECK;
            ST_CHECK:  state_next = (since > TIME_BITS'(period_reg)) ? ST_MIX_A : ST_IDLE;
            ST_MIX_A:  state_next = ST_MIX_B;
            ST_MIX_B:  state_next = ST_AVG;
            ST_AVG:    state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_DIV;
            ST_DIV:    state_next = div_stat.done ? ST_SAT : ST_DIV;
            ST_SAT:    state_next = ST_LIMIT;
            ST_LIMIT:  state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            finish_reg      <= 1'b0;
            now_reg         <= '0;
            last_check_reg  <= '0;
            prog_start_reg  <= '0;
            last_trip_reg   <= '0;
            avg_reg         <= '0;
            window_left_reg <= totr_pkg::RST_WINDOW;
            enabled_reg     <= 1'b0;
            tripped_reg     <= 1'b0;
            prog_reg        <= 1'b0;
            current_reg     <= '0;
            limit_reg       <= 1'b0;
            ev_reg          <= totr_pkg::EV_NONE;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                finish_reg <= 1'b0;
            end
            if (cfg_wr && totr_pkg::reg_idx_t'(paddr[4:2]) == totr_pkg::REG_WINDOW) begin
                window_left_reg <= pwdata[REG_W-1:0];
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_xfer) begin
                        case (totr_pkg::cmd_t'(s_cmd))
                            totr_pkg::CMD_TICK: begin
                                now_reg <= now_reg + TIME_BITS'(1);
                                ev_reg  <= totr_pkg::EV_NONE;
                            end
                            totr_pkg::CMD_POWER: begin
                                finish_reg  <= 1'b1;
                                enabled_reg <= s_value;
                                if (prog_reg) begin
                                    prog_start_reg <= now_reg;
                                end
                                if (s_announce) begin
                                    ev_reg <= s_value ? totr_pkg::EV_ON : totr_pkg::EV_OFF;
                                end else begin
                                    ev_reg <= totr_pkg::EV_NONE;
                                end
                            end
                            totr_pkg::CMD_PROG: begin
                                finish_reg <= 1'b1;
                                prog_reg   <= s_value;
                                ev_reg     <= totr_pkg::EV_NONE;
                            end
                            default: begin
                                finish_reg <= 1'b1;
                                ev_reg     <= totr_pkg::EV_NONE;
                            end
                        endcase
                    end
                end
                ST_TICK: begin
                    // window expiry
                    if (since > window_ext) begin
                        window_left_reg <= '0;
                    end
                end
                ST_CHECK: begin
                    if (since > TIME_BITS'(period_reg)) begin
                        last_check_reg <= now_reg;
                    end else begin
                        finish_reg <= 1'b1;
                    end
                end
                ST_AVG: begin
                    avg_reg <= acc_reg[AVG_W+7:8];
                end
                ST_SAT: begin
                    current_reg <= (|quotient[DVD_W-1:REG_W]) ? totr_pkg::CURRENT_MAX
                                                               : quotient[REG_W-1:0];
                end
                ST_LIMIT: begin
                    limit_reg <= prog_reg && ((since < window_ext) || (window_left_reg == '0));
                end
                ST_DECIDE: begin
                    finish_reg <= 1'b1;
                    if (current_reg > limit_ma && enabled_reg) begin
                        enabled_reg   <= 1'b0;
                        tripped_reg   <= 1'b1;
                        last_trip_reg <= now_reg;
                        ev_reg        <= totr_pkg::EV_OFF;
                        if (prog_reg) begin
                            prog_start_reg <= now_reg;
                        end
                    end else if (current_reg < limit_ma && tripped_reg &&
                                 since > TIME_BITS'(retry_reg)) begin
                        enabled_reg <= 1'b1;
                        tripped_reg <= 1'b0;
                        ev_reg      <= totr_pkg::EV_ON;
                        if (prog_reg) begin
                            prog_start_reg <= now_reg;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers of the tick path
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            sample_reg <= s_sample;
        end
        case (state_reg)
            ST_MIX_A: acc_reg <= prod[MIX_W-1:0];
            ST_MIX_B: acc_reg <= acc_reg + prod[MIX_W-1:0];
            default: ;
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_enabled_reg  <= enabled_reg;
            m_tripped_reg  <= tripped_reg;
            m_current_reg  <= current_reg;
            m_event_reg    <= ev_reg;
            m_limiting_reg <= limit_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_power_enabled = m_enabled_reg;
    assign m_is_tripped    = m_tripped_reg;
    assign m_current_ma    = m_current_reg;
    assign m_power_event   = m_event_reg;
    assign m_limiting      = m_limiting_reg;

    // ---------------- assertions ----------------
    `TOTR_ASSERT_IMPLY(a_div_start_idle, aclk, aresetn, div_start, !div_stat.busy)
    `TOTR_ASSERT_NEXT(a_div_done_sat, aclk, aresetn,
        (state_reg == ST_DIV) && div_stat.done, state_reg == ST_SAT)
    `TOTR_ASSERT_NEXT(a_tick_advances, aclk, aresetn,
        in_xfer && s_cmd == totr_pkg::CMD_TICK,
        (state_reg == ST_TICK) && (now_reg == $past(now_reg) + TIME_BITS'(1)))
    `TOTR_ASSERT_NEXT(a_current_only_sat, aclk, aresetn,
        state_reg != ST_SAT, $stable(current_reg))
    `TOTR_ASSERT_NEXT(a_finish_loads, aclk, aresetn,
        finish_reg && !m_valid_reg, m_valid_reg && !finish_reg)

endmodule

### rtl/totr_div.sv
module totr_div #(
    parameter int DVD_W = 26,
    parameter int DSR_W = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [DVD_W-1:0]    dividend,
    input  logic [DSR_W-1:0]    divisor,
    output totr_pkg::div_stat_t stat,
    output logic [DVD_W-1:0]    quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [DSR_W-1:0] dsr_reg;

    logic [DSR_W:0]   trial;
    logic [DSR_W:0]   diff;
    logic             fits;

    // restoring division, one quotient bit per cycle, MSB first
    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule
